/* hdl/rotation_to_euler_angles_core_macros.svh */
// Assertion macros shared by the rotation to Euler angles core.
`ifndef ROTATION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define ROTATION_TO_EULER_ANGLES_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rte_pkg.sv */
// Constants, sequence table and helper function of the Euler angle core.
package rte_pkg;

    localparam int IO_FRAC    = 16;
    localparam int MODE_COUNT = 12;

    localparam logic signed [18:0] PI_OUT      = 19'sd205887;
    localparam logic signed [18:0] HALF_PI_OUT = 19'sd102944;
    localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;

    localparam logic [1:0] KIND_ACOS     = 2'd0;
    localparam logic [1:0] KIND_ASIN     = 2'd1;
    localparam logic [1:0] KIND_ASIN_NEG = 2'd2;

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    // operand codes are +-(element index + 1), elements row-major
    typedef struct packed {
        logic [3:0]         pivot;
        logic [1:0]         kind;
        logic signed [4:0]  ay;
        logic signed [4:0]  ax;
        logic signed [4:0]  gy;
        logic signed [4:0]  gx;
        logic signed [4:0]  uy;
        logic signed [4:0]  ux;
        logic signed [4:0]  ly;
        logic signed [4:0]  lx;
        logic signed [18:0] beta_up;
        logic signed [18:0] beta_low;
    } t_seq;

    localparam t_seq SEQ_TABLE [MODE_COUNT] = '{
        '{4'd8, KIND_ACOS, 5'sd3, -5'sd6, 5'sd7, 5'sd8, -5'sd3, 5'sd1, -5'sd2, 5'sd1,
          19'sd0, PI_OUT},
        '{4'd0, KIND_ACOS, 5'sd4, -5'sd7, 5'sd2, 5'sd3, -5'sd6, 5'sd5, -5'sd6, 5'sd5,
          19'sd0, PI_OUT},
        '{4'd4, KIND_ACOS, 5'sd8, -5'sd2, 5'sd6, 5'sd4, -5'sd7, 5'sd9, -5'sd7, 5'sd9,
          19'sd0, PI_OUT},
        '{4'd8, KIND_ACOS, 5'sd6, 5'sd3, 5'sd8, -5'sd7, 5'sd4, 5'sd5, 5'sd4, 5'sd5,
          19'sd0, PI_OUT},
        '{4'd0, KIND_ACOS, 5'sd7, 5'sd4, 5'sd3, -5'sd2, 5'sd8, 5'sd9, 5'sd8, 5'sd9,
          19'sd0, PI_OUT},
        '{4'd4, KIND_ACOS, 5'sd2, 5'sd8, 5'sd4, -5'sd6, 5'sd3, 5'sd1, 5'sd3, 5'sd1,
          19'sd0, PI_OUT},
        '{4'd2, KIND_ASIN, -5'sd6, 5'sd9, -5'sd2, 5'sd1, 5'sd4, 5'sd5, 5'sd4, 5'sd5,
          HALF_PI_OUT, -HALF_PI_OUT},
        '{4'd3, KIND_ASIN, -5'sd7, 5'sd1, -5'sd6, 5'sd5, 5'sd8, 5'sd9, 5'sd8, 5'sd9,
          HALF_PI_OUT, HALF_PI_OUT},
        '{4'd7, KIND_ASIN, -5'sd2, 5'sd5, -5'sd7, 5'sd9, 5'sd3, 5'sd1, 5'sd3, 5'sd1,
          HALF_PI_OUT, HALF_PI_OUT},
        '{4'd1, KIND_ASIN_NEG, 5'sd8, 5'sd5, 5'sd3, 5'sd1, -5'sd7, 5'sd9, -5'sd7, 5'sd9,
          HALF_PI_OUT, HALF_PI_OUT},
        '{4'd6, KIND_ASIN_NEG, 5'sd4, 5'sd1, 5'sd8, 5'sd9, -5'sd6, 5'sd5, -5'sd6, 5'sd5,
          -HALF_PI_OUT, HALF_PI_OUT},
        '{4'd5, KIND_ASIN_NEG, 5'sd3, 5'sd9, 5'sd4, 5'sd5, -5'sd2, 5'sd1, -5'sd2, 5'sd1,
          HALF_PI_OUT, HALF_PI_OUT}
    };

    // Q30 value rounded half up to fb fraction bits
    function automatic logic [31:0] q30_to_frac(input logic [31:0] v, input int fb);
        int          s;
        logic [32:0] t;
        s = 30 - fb;
        if (s <= 0) begin
            return v;
        end
        t = ({1'b0, v} + (33'd1 << (s - 1))) >> s;
        return t[31:0];
    endfunction

endpackage

/* hdl/rte_sqrt.sv */
// Pipelined integer square root of 1 - p*p, one result bit per stage.
module rte_sqrt import rte_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [2*FRACTION_BITS+3:0] i_pp,
    output logic [FRACTION_BITS:0]          o_root
);

    localparam int F   = FRACTION_BITS;
    localparam int PW  = 2 * F + 4;
    localparam int NW  = 2 * F + 1;

    logic [PW-1:0] one_sq;
    logic [PW-1:0] diff;
    logic [NW-1:0] r_n [F+2];
    logic [NW-1:0] r_r [F+2];

    assign one_sq = PW'(1) << (2 * F);
    assign diff   = one_sq - PW'(i_pp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= diff[NW-1:0];
            r_r[0] <= '0;
        end
    end

    for (genvar k = 0; k <= F; k++) begin : g_step
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (F - k));
        logic [NW:0]   sum;
        logic [NW-1:0] n_n;
        logic [NW-1:0] n_r;

        always_comb begin
            sum = {1'b0, r_r[k]} + {1'b0, BIT};
            if ({1'b0, r_n[k]} >= sum) begin
                n_n = r_n[k] - sum[NW-1:0];
                n_r = (r_r[k] >> 1) + BIT;
            end else begin
                n_n = r_n[k];
                n_r = r_r[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1] <= n_n;
                r_r[k+1] <= n_r;
            end
        end
    end

    assign o_root = r_r[F+1][F:0];

endmodule

/* hdl/rte_cordic.sv */
// Unrolled vectoring CORDIC atan2 with quadrant pre-rotation and output scaling.
module rte_cordic import rte_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [FRACTION_BITS+4:0] i_y,
    input  logic signed [FRACTION_BITS+4:0] i_x,
    output logic signed [18:0]              o_angle
);

    localparam int F   = FRACTION_BITS;
    localparam int S   = CORDIC_STAGES;
    localparam int CW  = F + 5;
    localparam int ZW  = F + 4;
    localparam int OW  = ZW + 16;
    localparam int RN  = (F > IO_FRAC) ? F - IO_FRAC : 0;
    localparam int LS  = (F > IO_FRAC) ? 0 : IO_FRAC - F;
    localparam logic signed [OW-1:0] RND = signed'((OW'(1) << RN) >> 1);
    localparam logic signed [ZW-1:0] HALF_PI = signed'(ZW'(q30_to_frac(HALF_PI_Q30, F)));

    logic signed [CW-1:0] r_x [S+1];
    logic signed [CW-1:0] r_y [S+1];
    logic signed [ZW-1:0] r_z [S+1];
    logic                 r_zero [S+1];
    logic signed [18:0]   r_angle;

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;

    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = signed'(ZW'(q30_to_frac(ATAN_Q30[k], F)));
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = r_x[k] >>> k;
        assign dy = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] < 0) begin
                    r_x[k+1] <= r_x[k] - dy;
                    r_y[k+1] <= r_y[k] + dx;
                    r_z[k+1] <= r_z[k] - ANG;
                end else begin
                    r_x[k+1] <= r_x[k] + dy;
                    r_y[k+1] <= r_y[k] - dx;
                    r_z[k+1] <= r_z[k] + ANG;
                end
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    logic signed [OW-1:0] zx;
    logic signed [OW-1:0] scaled;
    logic signed [18:0]   n_angle;

    always_comb begin
        zx     = OW'(r_z[S]);
        scaled = ((zx + RND) >>> RN) <<< LS;
        if (r_zero[S]) begin
            n_angle = '0;
        end else if (scaled > OW'(PI_OUT)) begin
            n_angle = PI_OUT;
        end else if (scaled < -OW'(PI_OUT)) begin
            n_angle = -PI_OUT;
        end else begin
            n_angle = scaled[18:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* hdl/rotation_to_euler_angles_core.sv */
// Top level: rotation matrix to Euler angles for twelve sequences.
// A beat on the input channel carries a sequence selector and a 3x3 rotation
// matrix in Q2.16; a beat on the output channel carries alpha, beta, gamma in
// Q3.16 radians and mode_ok. Every input beat yields exactly one output beat,
// in order.
// Stages in order: input register, decode and pivot square, square root of
// one bit per stage (FRACTION_BITS + 2), three parallel CORDIC units
// (CORDIC_STAGES + 2) and the output register. A new matrix is taken every
// cycle while o_stall is low.
// The whole pipeline advances together; while the output register holds a
// beat that the receiver stalls, the pipeline holds and o_stall is raised,
// so nothing is lost or repeated.
// Reset clears all valid bits; no result is pending afterwards.
// Pivot at or beyond +-1.0 selects the gimbal lock result with gamma zero;
// selectors 12 to 15 return zero angles with mode_ok low.
`include "rotation_to_euler_angles_core_macros.svh"
module rotation_to_euler_angles_core import rte_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_mode,
    input  logic signed [17:0] i_row0_col0,
    input  logic signed [17:0] i_row0_col1,
    input  logic signed [17:0] i_row0_col2,
    input  logic signed [17:0] i_row1_col0,
    input  logic signed [17:0] i_row1_col1,
    input  logic signed [17:0] i_row1_col2,
    input  logic signed [17:0] i_row2_col0,
    input  logic signed [17:0] i_row2_col1,
    input  logic signed [17:0] i_row2_col2,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [18:0] o_alpha,
    output logic signed [18:0] o_beta,
    output logic signed [18:0] o_gamma,
    output logic               o_mode_ok
);

    localparam int F      = FRACTION_BITS;
    localparam int EW     = F + 2;
    localparam int CW     = F + 5;
    localparam int XW     = F + 18;
    localparam int SQW    = F + 1;
    localparam int SHL    = (F >= IO_FRAC) ? F - IO_FRAC : 0;
    localparam int SHR    = (F >= IO_FRAC) ? 0 : IO_FRAC - F;
    localparam int L_SQ   = F + 2;
    localparam int L_SIDE = L_SQ + CORDIC_STAGES + 2;

    typedef struct packed {
        logic               ok;
        logic               up;
        logic               low;
        logic [1:0]         kind;
        logic signed [18:0] beta_lock;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] gy;
        logic signed [CW-1:0] gx;
        logic signed [EW-1:0] p;
    } t_ops;

    function automatic logic signed [CW-1:0] pick(input logic signed [4:0] code,
                                                  input logic signed [EW-1:0] el [9]);
        logic signed [4:0]    mag;
        logic [3:0]           idx;
        logic signed [CW-1:0] v;
        mag = (code < 0) ? -code : code;
        idx = 4'(mag - 5'sd1);
        v   = CW'(el[idx]);
        return (code < 0) ? -v : v;
    endfunction

    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // stage A: input register
    logic               r_a_valid;
    logic [3:0]         r_a_mode;
    logic signed [17:0] r_a_raw [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode   <= i_mode;
            r_a_raw[0] <= i_row0_col0;
            r_a_raw[1] <= i_row0_col1;
            r_a_raw[2] <= i_row0_col2;
            r_a_raw[3] <= i_row1_col0;
            r_a_raw[4] <= i_row1_col1;
            r_a_raw[5] <= i_row1_col2;
            r_a_raw[6] <= i_row2_col0;
            r_a_raw[7] <= i_row2_col1;
            r_a_raw[8] <= i_row2_col2;
        end
    end

    // stage B: decode, operand select, pivot square
    logic signed [EW-1:0]   e [9];
    logic signed [XW-1:0]   xt [9];
    t_seq                   row;
    logic [3:0]             sel;
    logic signed [17:0]     pr;
    t_side                  n_side;
    t_ops                   n_ops;
    logic signed [2*EW-1:0] n_pp;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            xt[k] = (XW'(r_a_raw[k]) <<< SHL) >>> SHR;
            e[k]  = xt[k][EW-1:0];
        end
        n_side.ok = (r_a_mode < 4'(MODE_COUNT));
        sel       = n_side.ok ? r_a_mode : 4'd0;
        row       = SEQ_TABLE[sel];
        pr        = r_a_raw[row.pivot];
        n_side.up   = (pr >= 18'sd65536);
        n_side.low  = !n_side.up && (pr <= -18'sd65536);
        n_side.kind = row.kind;
        n_side.beta_lock = n_side.up ? row.beta_up : row.beta_low;
        if (n_side.up) begin
            n_ops.ay = pick(row.uy, e);
            n_ops.ax = pick(row.ux, e);
        end else if (n_side.low) begin
            n_ops.ay = pick(row.ly, e);
            n_ops.ax = pick(row.lx, e);
        end else begin
            n_ops.ay = pick(row.ay, e);
            n_ops.ax = pick(row.ax, e);
        end
        n_ops.gy = pick(row.gy, e);
        n_ops.gx = pick(row.gx, e);
        n_ops.p  = e[row.pivot];
        n_pp     = n_ops.p * n_ops.p;
    end

    logic                   r_b_valid;
    t_side                  r_b_side;
    t_ops                   r_b_ops;
    logic signed [2*EW-1:0] r_b_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side <= n_side;
            r_b_ops  <= n_ops;
            r_b_pp   <= n_pp;
        end
    end

    // square root of 1 - p*p
    logic [SQW-1:0] root;

    rte_sqrt #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pp   (r_b_pp),
        .o_root (root)
    );

    // operands wait for the root; side info waits for the angles
    t_ops              r_ops_dly  [L_SQ];
    t_side             r_side_dly [L_SIDE];
    logic [L_SIDE-1:0] r_vld_dly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_dly <= '0;
        end else if (en) begin
            r_vld_dly <= {r_vld_dly[L_SIDE-2:0], r_b_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ops_dly[0]  <= r_b_ops;
            r_side_dly[0] <= r_b_side;
            for (int k = 1; k < L_SQ; k++) begin
                r_ops_dly[k] <= r_ops_dly[k-1];
            end
            for (int k = 1; k < L_SIDE; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    t_ops                 ops_q;
    t_side                side_q;
    logic signed [CW-1:0] sq_c;
    logic signed [CW-1:0] p_c;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bx;

    assign ops_q  = r_ops_dly[L_SQ-1];
    assign side_q = r_side_dly[L_SQ-1];
    assign sq_c   = signed'(CW'(root));
    assign p_c    = CW'(ops_q.p);

    always_comb begin
        case (side_q.kind)
            KIND_ACOS: begin
                by = sq_c;
                bx = p_c;
            end
            KIND_ASIN: begin
                by = p_c;
                bx = sq_c;
            end
            default: begin
                by = -p_c;
                bx = sq_c;
            end
        endcase
    end

    logic signed [18:0] za;
    logic signed [18:0] zb;
    logic signed [18:0] zg;

    rte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cordic_alpha (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (ops_q.ay),
        .i_x     (ops_q.ax),
        .o_angle (za)
    );

    rte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cordic_beta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (by),
        .i_x     (bx),
        .o_angle (zb)
    );

    rte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cordic_gamma (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (ops_q.gy),
        .i_x     (ops_q.gx),
        .o_angle (zg)
    );

    // output stage
    t_side              side_f;
    logic               vld_f;
    logic signed [18:0] n_alpha;
    logic signed [18:0] n_beta;
    logic signed [18:0] n_gamma;

    assign side_f = r_side_dly[L_SIDE-1];
    assign vld_f  = r_vld_dly[L_SIDE-1];

    always_comb begin
        n_alpha = '0;
        n_beta  = '0;
        n_gamma = '0;
        if (side_f.ok) begin
            if (side_f.up) begin
                n_alpha = za;
                n_beta  = side_f.beta_lock;
            end else if (side_f.low) begin
                n_alpha = -za;
                n_beta  = side_f.beta_lock;
            end else begin
                n_alpha = za;
                n_beta  = zb;
                n_gamma = zg;
            end
        end
    end

    logic               r_out_valid;
    logic signed [18:0] r_alpha;
    logic signed [18:0] r_beta;
    logic signed [18:0] r_gamma;
    logic               r_mode_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vld_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha   <= n_alpha;
            r_beta    <= n_beta;
            r_gamma   <= n_gamma;
            r_mode_ok <= side_f.ok;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_alpha   = r_alpha;
    assign o_beta    = r_beta;
    assign o_gamma   = r_gamma;
    assign o_mode_ok = r_mode_ok;

    `RTE_ASSERT_IMP(a_bad_mode_zero, i_clk, i_rst_n, o_valid && !o_mode_ok, (o_alpha == 0) && (o_beta == 0) && (o_gamma == 0))
    `RTE_ASSERT_NXT(a_lock_gamma_zero, i_clk, i_rst_n, en && vld_f && (side_f.up || side_f.low), o_valid && (o_gamma == 0))
    `RTE_ASSERT_NXT(a_beat_reaches_out, i_clk, i_rst_n, en && vld_f, o_valid)

endmodule

/* sim/tb_rotation_to_euler_angles_core.sv */
// Testbench for rotation_to_euler_angles_core: directed table, random beats, self-checking.
module tb_rotation_to_euler_angles_core;
    import rte_pkg::*;

    localparam int N_RANDOM  = 1100;
    localparam int QUIET_TAIL = 150;
    localparam int LATENCY   = 39;
    localparam int STAGES    = 16;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 300;
    localparam logic [3:0] MODE_ZXZ = 4'd0;
    localparam logic [3:0] MODE_XYZ = 4'd6;
    localparam logic [3:0] MODE_BAD_LO = 4'd12;
    localparam logic [3:0] MODE_BAD_HI = 4'd15;

    typedef logic signed [17:0] t_elem;
    typedef t_elem t_mat [9];
    typedef struct {
        logic [3:0] mode;
        t_mat       el;
    } t_beat;
    typedef struct {
        logic signed [18:0] alpha;
        logic signed [18:0] beta;
        logic signed [18:0] gamma;
        logic               ok;
    } t_angles;
    typedef struct {
        logic [3:0] mode;
        t_mat       el;
        bit         typed;
        t_angles    want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [3:0]         i_mode = '0;
    logic signed [17:0] i_el [9];
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [18:0] o_alpha, o_beta, o_gamma;
    logic               o_mode_ok;

    t_angles pending_angles [$];
    t_row    dir_tab [$];
    int      n_sent = 0;
    int      n_err = 0;
    int      n_cycles = 0;
    bit      quiet = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_cnt = 0;
    int      burst_cnt = 0;

    initial for (int k = 0; k < 9; k++) i_el[k] = '0;

    always #2 i_clk = ~i_clk;

    rotation_to_euler_angles_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode),
        .i_row0_col0(i_el[0]), .i_row0_col1(i_el[1]), .i_row0_col2(i_el[2]),
        .i_row1_col0(i_el[3]), .i_row1_col1(i_el[4]), .i_row1_col2(i_el[5]),
        .i_row2_col0(i_el[6]), .i_row2_col1(i_el[7]), .i_row2_col2(i_el[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_alpha(o_alpha), .o_beta(o_beta), .o_gamma(o_gamma), .o_mode_ok(o_mode_ok)
    );

    function automatic longint q30_round(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z, t, dx, dy, a;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = q30_round(longint'(HALF_PI_Q30));
            end else begin
                x = -y; y = t; z = -q30_round(longint'(HALF_PI_Q30));
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            a = q30_round(longint'(ATAN_Q30[i]));
            if (y < 0) begin
                x -= dy; y += dx; z -= a;
            end else begin
                x += dy; y -= dx; z += a;
            end
        end
        if (z > longint'(PI_OUT)) z = longint'(PI_OUT);
        if (z < -longint'(PI_OUT)) z = -longint'(PI_OUT);
        return z;
    endfunction

    function automatic longint pick(longint e [9], logic signed [4:0] code);
        int c;
        c = (code < 0) ? -int'(code) : int'(code);
        return (code < 0) ? -e[c-1] : e[c-1];
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b; r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic t_angles euler_of(t_beat bt);
        t_angles res;
        longint  e [9];
        longint  a, b, g, p, sq;
        t_seq    s;
        a = 0; b = 0; g = 0;
        res.ok = 1'b0;
        for (int k = 0; k < 9; k++) e[k] = longint'(bt.el[k]);
        if (bt.mode < MODE_COUNT) begin
            s = SEQ_TABLE[bt.mode];
            p = e[s.pivot];
            res.ok = 1'b1;
            if (p >= 65536) begin
                b = longint'(s.beta_up);
                a = cordic_angle(pick(e, s.uy), pick(e, s.ux));
            end else if (p <= -65536) begin
                b = longint'(s.beta_low);
                a = -cordic_angle(pick(e, s.ly), pick(e, s.lx));
            end else begin
                sq = int_sqrt(64'sd65536 * 64'sd65536 - p * p);
                case (s.kind)
                    KIND_ACOS: b = cordic_angle(sq, p);
                    KIND_ASIN: b = cordic_angle(p, sq);
                    default:   b = cordic_angle(-p, sq);
                endcase
                a = cordic_angle(pick(e, s.ay), pick(e, s.ax));
                g = cordic_angle(pick(e, s.gy), pick(e, s.gx));
            end
        end
        res.alpha = a[18:0];
        res.beta  = b[18:0];
        res.gamma = g[18:0];
        return res;
    endfunction

    // present one beat, hold it until accepted, then maybe idle
    task automatic offer(t_beat bt, t_angles exp_angles);
        int gap;
        i_valid <= 1'b1;
        i_mode  <= bt.mode;
        for (int k = 0; k < 9; k++) i_el[k] <= bt.el[k];
        do @(posedge i_clk); while (o_stall);
        pending_angles.push_back(exp_angles);
        n_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(logic [3:0] mode, t_mat el, bit typed, t_angles want);
        t_row rw;
        rw.mode  = mode;
        rw.el    = el;
        rw.typed = typed;
        rw.want  = want;
        dir_tab.push_back(rw);
    endtask

    function automatic t_elem rand_elem();
        case ($urandom_range(0, 9))
            0: return t_elem'($urandom);
            1: return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
            default: return t_elem'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold once the pipe is busy
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= (hold_cnt > 1);
        end else if (!hold_done && n_sent >= 400) begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (burst_cnt > 0) begin
            burst_cnt <= burst_cnt - 1;
            i_stall   <= (burst_cnt > 1);
        end else if ($urandom_range(0, 7) == 0) begin
            burst_cnt <= $urandom_range(1, 13);
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_angles want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_angles.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected output beat alpha=%0d", o_alpha);
            end else begin
                want = pending_angles.pop_front();
                if (o_alpha !== want.alpha || o_beta !== want.beta
                        || o_gamma !== want.gamma || o_mode_ok !== want.ok) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 want.alpha, want.beta, want.gamma, want.ok,
                                 o_alpha, o_beta, o_gamma, o_mode_ok);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_angles zeros, lock_low, none;
        t_beat   bt;
        int      t;
        zeros = '{alpha: '0, beta: '0, gamma: '0, ok: 1'b1};
        none  = '{alpha: '0, beta: '0, gamma: '0, ok: 1'b0};
        lock_low = '{alpha: '0, beta: -HALF_PI_OUT, gamma: '0, ok: 1'b1};

        // unknown selectors at the element extremes
        add_row(MODE_BAD_LO, '{default: 18'sh1FFFF}, 1, none);
        add_row(MODE_BAD_HI, '{default: -18'sh20000}, 1, none);
        // lock with all-zero operands: atan2(0,0)
        add_row(MODE_ZXZ, '{0, 0, 0, 0, 0, 0, 0, 0, 65536}, 1, zeros);
        add_row(MODE_XYZ, '{0, 0, -65536, 0, 0, 0, 0, 0, 0}, 1, lock_low);
        // identity and negated identity for every sequence
        for (int md = 0; md < MODE_COUNT; md++) begin
            add_row(md[3:0], '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536}, 0, none);
            add_row(md[3:0], '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536}, 0, none);
        end
        // zero over negative, pivots beyond range, full-scale elements
        add_row(MODE_ZXZ, '{-65536, 0, 0, 0, 0, 0, 0, 0, 65536}, 0, none);
        add_row(4'd7, '{0, 0, 0, -131072, 0, 0, 0, 0, 0}, 0, none);
        add_row(4'd10, '{0, 0, 0, 0, 0, 0, 131071, 0, 0}, 0, none);
        add_row(4'd3, '{default: 18'sh1FFFF}, 0, none);
        add_row(4'd9, '{default: -18'sh20000}, 0, none);
        add_row(4'd1, '{30000, -40000, 1, 5, -5, 46341, -46341, 0, 65535}, 0, none);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            bt.mode = dir_tab[i].mode;
            bt.el   = dir_tab[i].el;
            offer(bt, dir_tab[i].typed ? dir_tab[i].want : euler_of(bt));
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            bt.mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11));
            for (int k = 0; k < 9; k++) bt.el[k] = rand_elem();
            if (bt.mode < MODE_COUNT && $urandom_range(0, 5) == 0)
                bt.el[SEQ_TABLE[bt.mode].pivot] = $urandom_range(0, 1) ? 18'sd65536
                                                                       : -18'sd65536;
            offer(bt, euler_of(bt));
        end
        i_valid <= 1'b0;
        quiet = 1'b1;

        t = 0;
        while (pending_angles.size() != 0 && t < 20000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_err == 0 && pending_angles.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
